### rtl/touch_median_calibrate_assert.svh
// Assertion macros used by the checker file of the touch filter.
`ifndef TOUCH_MEDIAN_CALIBRATE_ASSERT_SVH
`define TOUCH_MEDIAN_CALIBRATE_ASSERT_SVH

// Checked only outside reset.
`define TMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tmc_pkg.sv
package tmc_pkg;

  // Sample and coordinate widths.
  localparam int SAMPLE_BITS = 10;
  localparam int SCREEN_W    = 16;
  localparam int GAIN_W      = 19;
  localparam int OFFSET_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  // Reset value of a gain: 1.0 with 16 fractional bits.
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONVERT_ENABLE = 3'd0,
    CFG_X_GAIN         = 3'd1,
    CFG_Y_GAIN         = 3'd2,
    CFG_X_OFFSET       = 3'd3,
    CFG_Y_OFFSET       = 3'd4
  } cfg_index_t;

  // One result item.
  typedef struct packed {
    logic                   pressed;
    logic                   caught;
    logic                   coord_ready;
    logic [SAMPLE_BITS-1:0] raw_x;
    logic [SAMPLE_BITS-1:0] raw_y;
    logic [SCREEN_W-1:0]    screen_x;
    logic [SCREEN_W-1:0]    screen_y;
  } result_t;

endpackage

### rtl/touch_median_calibrate.sv
// Touch-panel reading filter and calibrator. Each request carries one panel
// reading; pen-down readings are grouped in bursts of three, and the third
// one yields the per-axis median (coord_ready high), which is held as the raw
// coordinate and, with convert_enable set, mapped to a screen coordinate as
// trunc(gain * raw / 65536) + offset, wrapped to 16 bits. A pen-up reading
// aborts a partial burst and zeros the held coordinates. Every request gives
// exactly one result. The block accepts one request per clock; the median,
// the 19x11 multiply and the offset add are done in the accept cycle, and
// when the out_ channel is free the result is offered in the next cycle. A
// two-entry output buffer takes one more request in a cycle where the
// consumer stalls; in_ready is low while both entries are full and rises in
// the cycle after the consumer takes a result. Configuration writes are
// always accepted (cfg_ready is tied high) and take effect on the next
// request; indexes above four are ignored.
module touch_median_calibrate (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Reading channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_pen_down,
  input  logic [tmc_pkg::SAMPLE_BITS-1:0]   in_x_sample,
  input  logic [tmc_pkg::SAMPLE_BITS-1:0]   in_y_sample,
  input  logic                              in_clear_caught,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_pressed,
  output logic                              out_caught,
  output logic                              out_coord_ready,
  output logic [tmc_pkg::SAMPLE_BITS-1:0]   out_raw_x,
  output logic [tmc_pkg::SAMPLE_BITS-1:0]   out_raw_y,
  output logic [tmc_pkg::SCREEN_W-1:0]      out_screen_x,
  output logic [tmc_pkg::SCREEN_W-1:0]      out_screen_y
);

  localparam int SB     = tmc_pkg::SAMPLE_BITS;
  localparam int SW     = tmc_pkg::SCREEN_W;
  localparam int PROD_W = tmc_pkg::GAIN_W + SB + 1;

  // Median of three, with the comparison order of the scan routine.
  function automatic logic [SB-1:0] mid3(input logic [SB-1:0] a,
                                         input logic [SB-1:0] b,
                                         input logic [SB-1:0] c);
    logic [SB-1:0] m;
    if (a > b) begin
      if (b > c) m = b;
      else       m = (a > c) ? c : a;
    end else begin
      if (b < c) m = b;
      else       m = (a < c) ? c : a;
    end
    return m;
  endfunction

  // Scale by a signed gain, truncate toward zero, add offset, wrap.
  function automatic logic [SW-1:0] scale_axis(
    input logic signed [tmc_pkg::GAIN_W-1:0]   gain,
    input logic        [SB-1:0]                raw,
    input logic        [tmc_pkg::OFFSET_W-1:0] offset);
    logic signed [PROD_W-1:0]  prod;
    logic        [PROD_W-1:0]  mag;
    logic        [PROD_W+SW-1:0] mag_ext;
    logic        [SW-1:0]      q;
    prod    = PROD_W'(gain) * $signed({1'b0, raw});
    mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    mag_ext = {{SW{1'b0}}, mag};
    q       = mag_ext[tmc_pkg::FRAC_BITS +: SW];
    if (prod[PROD_W-1]) q = SW'(-q);
    return SW'(q + SW'(offset));
  endfunction

  // Configuration registers.
  logic                                  convert_enable_r;
  logic signed [tmc_pkg::GAIN_W-1:0]     x_gain_r, y_gain_r;
  logic        [tmc_pkg::OFFSET_W-1:0]   x_offset_r, y_offset_r;

  // Burst and held state.
  logic [1:0]    sample_count_r, sample_count_nxt;
  logic [SB-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic [SB-1:0] first_x_nxt, first_y_nxt, second_x_nxt, second_y_nxt;
  logic [SB-1:0] held_raw_x_r, held_raw_y_r, held_raw_x_nxt, held_raw_y_nxt;
  logic [SW-1:0] held_scr_x_r, held_scr_y_r, held_scr_x_nxt, held_scr_y_nxt;
  logic          pressed_r, caught_r, pressed_nxt, caught_nxt;
  logic          coord_ready;

  // Output buffer: main entry and skid entry.
  tmc_pkg::result_t out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             in_acc, out_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_pop   = out_valid_r && out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_enable_r <= 1'b0;
      x_gain_r         <= tmc_pkg::GAIN_ONE;
      y_gain_r         <= tmc_pkg::GAIN_ONE;
      x_offset_r       <= '0;
      y_offset_r       <= '0;
    end else if (cfg_valid) begin
      case (tmc_pkg::cfg_index_t'(cfg_index))
        tmc_pkg::CFG_CONVERT_ENABLE: convert_enable_r <= cfg_data[0];
        tmc_pkg::CFG_X_GAIN:         x_gain_r   <= cfg_data[tmc_pkg::GAIN_W-1:0];
        tmc_pkg::CFG_Y_GAIN:         y_gain_r   <= cfg_data[tmc_pkg::GAIN_W-1:0];
        tmc_pkg::CFG_X_OFFSET:       x_offset_r <= cfg_data[tmc_pkg::OFFSET_W-1:0];
        tmc_pkg::CFG_Y_OFFSET:       y_offset_r <= cfg_data[tmc_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-reading update of burst, held coordinates and press flags.
  always_comb begin
    sample_count_nxt = sample_count_r;
    first_x_nxt      = first_x_r;
    first_y_nxt      = first_y_r;
    second_x_nxt     = second_x_r;
    second_y_nxt     = second_y_r;
    held_raw_x_nxt   = held_raw_x_r;
    held_raw_y_nxt   = held_raw_y_r;
    held_scr_x_nxt   = held_scr_x_r;
    held_scr_y_nxt   = held_scr_y_r;
    pressed_nxt      = pressed_r;
    caught_nxt       = caught_r && !in_clear_caught;
    coord_ready      = 1'b0;
    if (in_pen_down) begin
      case (sample_count_r)
        2'd0: begin
          first_x_nxt      = in_x_sample;
          first_y_nxt      = in_y_sample;
          sample_count_nxt = 2'd1;
        end
        2'd1: begin
          second_x_nxt     = in_x_sample;
          second_y_nxt     = in_y_sample;
          sample_count_nxt = 2'd2;
        end
        default: begin
          held_raw_x_nxt = mid3(first_x_r, second_x_r, in_x_sample);
          held_raw_y_nxt = mid3(first_y_r, second_y_r, in_y_sample);
          if (convert_enable_r) begin
            held_scr_x_nxt = scale_axis(x_gain_r, held_raw_x_nxt, x_offset_r);
            held_scr_y_nxt = scale_axis(y_gain_r, held_raw_y_nxt, y_offset_r);
          end
          sample_count_nxt = 2'd0;
          coord_ready      = 1'b1;
        end
      endcase
      if (!pressed_r) begin
        pressed_nxt = 1'b1;
        caught_nxt  = 1'b1;
      end
    end else begin
      // A pen-up in the middle of a burst drops the held coordinates.
      if (sample_count_r != 2'd0) begin
        held_raw_x_nxt   = '0;
        held_raw_y_nxt   = '0;
        held_scr_x_nxt   = '0;
        held_scr_y_nxt   = '0;
        sample_count_nxt = 2'd0;
      end
      pressed_nxt = 1'b0;
    end
  end

  // Result built from the updated state.
  always_comb begin
    res.pressed     = pressed_nxt;
    res.caught      = caught_nxt;
    res.coord_ready = coord_ready;
    res.raw_x       = held_raw_x_nxt;
    res.raw_y       = held_raw_y_nxt;
    res.screen_x    = held_scr_x_nxt;
    res.screen_y    = held_scr_y_nxt;
  end

  // State registers, updated on each accepted reading.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= 2'd0;
      first_x_r      <= '0;
      first_y_r      <= '0;
      second_x_r     <= '0;
      second_y_r     <= '0;
      held_raw_x_r   <= '0;
      held_raw_y_r   <= '0;
      held_scr_x_r   <= '0;
      held_scr_y_r   <= '0;
      pressed_r      <= 1'b0;
      caught_r       <= 1'b0;
    end else if (in_acc) begin
      sample_count_r <= sample_count_nxt;
      first_x_r      <= first_x_nxt;
      first_y_r      <= first_y_nxt;
      second_x_r     <= second_x_nxt;
      second_y_r     <= second_y_nxt;
      held_raw_x_r   <= held_raw_x_nxt;
      held_raw_y_r   <= held_raw_y_nxt;
      held_scr_x_r   <= held_scr_x_nxt;
      held_scr_y_r   <= held_scr_y_nxt;
      pressed_r      <= pressed_nxt;
      caught_r       <= caught_nxt;
    end
  end

  // Output buffer valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      if (out_valid_r) skid_valid_r <= 1'b1;
      else             out_valid_r  <= 1'b1;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_acc)  out_r <= res;
    end else if (in_acc) begin
      if (out_valid_r) skid_r <= res;
      else             out_r  <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pressed     = out_r.pressed;
  assign out_caught      = out_r.caught;
  assign out_coord_ready = out_r.coord_ready;
  assign out_raw_x       = out_r.raw_x;
  assign out_raw_y       = out_r.raw_y;
  assign out_screen_x    = out_r.screen_x;
  assign out_screen_y    = out_r.screen_y;

endmodule

### rtl/tmc_checker.sv
`include "touch_median_calibrate_assert.svh"

// Port-level checks for the touch filter.
module tmc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_pressed,
  input logic                              out_coord_ready,
  input logic [tmc_pkg::SAMPLE_BITS-1:0]   out_raw_x,
  input logic [tmc_pkg::SAMPLE_BITS-1:0]   out_raw_y,
  input logic [tmc_pkg::SCREEN_W-1:0]      out_screen_x,
  input logic [tmc_pkg::SCREEN_W-1:0]      out_screen_y
);

  // A stalled result stays offered.
  `TMC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `TMC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_raw_x) && $stable(out_raw_y) && $stable(out_screen_x) && $stable(out_screen_y) && $stable(out_coord_ready), "result changed while stalled")

  // A completed median only comes from a pen-down reading.
  `TMC_ASSERT(a_ready_pressed, out_valid && out_coord_ready |-> out_pressed, "median reported without press")

  // Reset leaves no result on offer.
  `TMC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind touch_median_calibrate tmc_checker u_tmc_checker (.*);

### sim/touch_median_calibrate_tb.sv
module touch_median_calibrate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmc_pkg::*;

  localparam int RESET_CYCLES       = 7;
  localparam int BATCHES            = 9;
  localparam int READINGS_PER_BATCH = 150;
  localparam int WATCHDOG_LIMIT     = 1000;
  localparam int DRAIN_CYCLES       = 10;
  localparam int GAIN_LIMIT         = 2 << FRAC_BITS;
  localparam int SAMPLE_MAX         = (1 << SAMPLE_BITS) - 1;
  localparam int OFFSET_SPAN        = 1 << OFFSET_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = CFG_IDX_W'((1 << CFG_IDX_W) - 1);

  // One panel reading as it travels on the input channel.
  typedef struct {
    logic                   pen_down;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic                   clear_caught;
  } reading_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   cfg_valid       = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data        = '0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic                   in_pen_down     = 1'b0;
  logic [SAMPLE_BITS-1:0] in_x_sample     = '0;
  logic [SAMPLE_BITS-1:0] in_y_sample     = '0;
  logic                   in_clear_caught = 1'b0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic                   out_pressed;
  logic                   out_caught;
  logic                   out_coord_ready;
  logic [SAMPLE_BITS-1:0] out_raw_x;
  logic [SAMPLE_BITS-1:0] out_raw_y;
  logic [SCREEN_W-1:0]    out_screen_x;
  logic [SCREEN_W-1:0]    out_screen_y;

  // Pending readings and the coordinates they are expected to produce.
  reading_t reading_queue[$];
  result_t  coord_queue[$];
  int       errors        = 0;
  int       quiet_cycles  = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  // Shadow of the calibration registers.
  logic                     conv_on = 1'b0;
  logic signed [GAIN_W-1:0] gain_x  = GAIN_ONE;
  logic signed [GAIN_W-1:0] gain_y  = GAIN_ONE;
  logic [OFFSET_W-1:0]      off_x   = '0;
  logic [OFFSET_W-1:0]      off_y   = '0;

  // Shadow of the filter state.
  logic [1:0]             burst_len = '0;
  logic [SAMPLE_BITS-1:0] first_xs  = '0;
  logic [SAMPLE_BITS-1:0] first_ys  = '0;
  logic [SAMPLE_BITS-1:0] second_xs = '0;
  logic [SAMPLE_BITS-1:0] second_ys = '0;
  logic [SAMPLE_BITS-1:0] hold_raw_x = '0;
  logic [SAMPLE_BITS-1:0] hold_raw_y = '0;
  logic [SCREEN_W-1:0]    hold_scr_x = '0;
  logic [SCREEN_W-1:0]    hold_scr_y = '0;
  logic                   pressed_q = 1'b0;
  logic                   caught_q  = 1'b0;

  touch_median_calibrate dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SAMPLE_BITS-1:0] median3(input logic [SAMPLE_BITS-1:0] a, b, c);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // Scale by a signed 16-fraction-bit gain, truncating toward zero, then add the offset.
  function automatic logic [SCREEN_W-1:0] calibrate_axis(input logic signed [GAIN_W-1:0] gain,
                                                         input logic [SAMPLE_BITS-1:0] raw,
                                                         input logic [OFFSET_W-1:0] off);
    longint              prod;
    longint              mag;
    logic [SCREEN_W-1:0] q;
    prod = longint'(gain) * longint'(raw);
    mag  = (prod < 0) ? -prod : prod;
    q    = mag[FRAC_BITS +: SCREEN_W];
    if (prod < 0) q = -q;
    return q + off;
  endfunction

  // Advance the shadow filter by one reading and return the coordinates it shows.
  function automatic result_t track_reading(input reading_t r);
    result_t res;
    logic    done;
    done = 1'b0;
    if (r.clear_caught) caught_q = 1'b0;
    if (r.pen_down) begin
      case (burst_len)
        2'd0: begin
          first_xs  = r.x_sample;
          first_ys  = r.y_sample;
          burst_len = 2'd1;
        end
        2'd1: begin
          second_xs = r.x_sample;
          second_ys = r.y_sample;
          burst_len = 2'd2;
        end
        default: begin
          hold_raw_x = median3(first_xs, second_xs, r.x_sample);
          hold_raw_y = median3(first_ys, second_ys, r.y_sample);
          if (conv_on) begin
            hold_scr_x = calibrate_axis(gain_x, hold_raw_x, off_x);
            hold_scr_y = calibrate_axis(gain_y, hold_raw_y, off_y);
          end
          burst_len = 2'd0;
          done      = 1'b1;
        end
      endcase
      if (!pressed_q) begin
        pressed_q = 1'b1;
        caught_q  = 1'b1;
      end
    end else begin
      // A pen-up in the middle of a burst wipes the held coordinates.
      if (burst_len != 2'd0) begin
        hold_raw_x = '0;
        hold_raw_y = '0;
        hold_scr_x = '0;
        hold_scr_y = '0;
        burst_len  = 2'd0;
      end
      pressed_q = 1'b0;
    end
    res.pressed     = pressed_q;
    res.caught      = caught_q;
    res.coord_ready = done;
    res.raw_x       = hold_raw_x;
    res.raw_y       = hold_raw_y;
    res.screen_x    = hold_scr_x;
    res.screen_y    = hold_scr_y;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [SCREEN_W-1:0] want,
                             input logic [SCREEN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: present queued readings, idling at random between requests.
  always @(posedge clk) begin
    reading_t pick;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (reading_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pick = reading_queue.pop_front();
        in_valid        <= 1'b1;
        in_pen_down     <= pick.pen_down;
        in_x_sample     <= pick.x_sample;
        in_y_sample     <= pick.y_sample;
        in_clear_caught <= pick.clear_caught;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Consumer side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results first, then track register writes and accepted readings.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (coord_queue.size() == 0) begin
          $display("%0t: result returned with no request outstanding", $time);
          errors++;
        end else begin
          want = coord_queue.pop_front();
          check_field("pressed", SCREEN_W'(want.pressed), SCREEN_W'(out_pressed));
          check_field("caught", SCREEN_W'(want.caught), SCREEN_W'(out_caught));
          check_field("coord_ready", SCREEN_W'(want.coord_ready),
                      SCREEN_W'(out_coord_ready));
          check_field("raw_x", SCREEN_W'(want.raw_x), SCREEN_W'(out_raw_x));
          check_field("raw_y", SCREEN_W'(want.raw_y), SCREEN_W'(out_raw_y));
          check_field("screen_x", want.screen_x, out_screen_x);
          check_field("screen_y", want.screen_y, out_screen_y);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONVERT_ENABLE: conv_on = cfg_data[0];
          CFG_X_GAIN:         gain_x  = cfg_data;
          CFG_Y_GAIN:         gain_y  = cfg_data;
          CFG_X_OFFSET:       off_x   = cfg_data[OFFSET_W-1:0];
          CFG_Y_OFFSET:       off_y   = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        coord_queue.push_back(track_reading(reading_t'{in_pen_down, in_x_sample,
                                                       in_y_sample, in_clear_caught}));
      end
    end
  end

  // Watchdog: give up when no channel makes progress for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_reading(input logic pen, input int xs, input int ys, input logic clr);
    reading_queue.push_back(reading_t'{pen, SAMPLE_BITS'(xs), SAMPLE_BITS'(ys), clr});
  endtask

  // Biased toward the ends of the range and toward near-equal values.
  function automatic int pick_sample();
    case ($urandom_range(7))
      0:       return 0;
      1:       return SAMPLE_MAX;
      2:       return $urandom_range(3);
      default: return $urandom_range(SAMPLE_MAX);
    endcase
  endfunction

  function automatic int rand_gain();
    return int'($urandom_range(2 * GAIN_LIMIT)) - GAIN_LIMIT;
  endfunction

  function automatic int rand_offset();
    return int'($urandom_range(OFFSET_SPAN - 1)) - OFFSET_SPAN / 2;
  endfunction

  // Mostly complete bursts with random content; the rest are aborted bursts and lone pen-ups.
  task automatic queue_random_readings(input int count);
    int made;
    int kind;
    int part;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 70) part = 3;
      else if (kind < 88) part = $urandom_range(1, 2);
      else part = 0;
      for (int i = 0; i < part; i++) begin
        push_reading(1'b1, pick_sample(), pick_sample(), $urandom_range(99) < 20);
      end
      made += part;
      if (part < 3) begin
        push_reading(1'b0, pick_sample(), pick_sample(), $urandom_range(99) < 30);
        made++;
      end
    end
  endtask

  // Block until every queued reading has been sent and answered.
  task automatic wait_idle();
    while (reading_queue.size() != 0 || in_valid || coord_queue.size() != 0) @(posedge clk);
  endtask

  // Caller must be at a rising edge; valid stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_calibration(input int conv, input int gx, input int gy,
                                  input int ox, input int oy);
    write_reg(CFG_CONVERT_ENABLE, conv);
    write_reg(CFG_X_GAIN, gx);
    write_reg(CFG_Y_GAIN, gy);
    write_reg(CFG_X_OFFSET, ox);
    write_reg(CFG_Y_OFFSET, oy);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 66;

    // Reset calibration, conversion off.
    push_reading(1'b0, 0, 0, 1'b0);                   // pen-up with no burst keeps zeros
    push_reading(1'b1, 0, SAMPLE_MAX, 1'b0);
    push_reading(1'b1, SAMPLE_MAX, 0, 1'b1);          // clear while already pressed
    push_reading(1'b1, 512, 512, 1'b0);
    push_reading(1'b0, 0, 0, 1'b0);                   // held median survives pen-up
    push_reading(1'b1, SAMPLE_MAX, SAMPLE_MAX, 1'b1); // clear together with a new press
    push_reading(1'b1, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    push_reading(1'b1, 0, 0, 1'b0);                   // tie on the top value
    push_reading(1'b1, 5, 7, 1'b0);
    push_reading(1'b0, 0, 0, 1'b1);                   // abort mid-burst zeros everything
    wait_idle();

    // Extreme gains and offsets; an unmapped index must change nothing.
    write_reg(CFG_IDX_W'($urandom_range(CFG_Y_OFFSET + 1, CFG_LAST_INDEX)), 0);
    load_calibration(1, GAIN_LIMIT, -GAIN_LIMIT, OFFSET_SPAN / 2 - 1, -OFFSET_SPAN / 2);
    repeat (3) push_reading(1'b1, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    repeat (3) push_reading(1'b1, 0, 0, 1'b0);
    push_reading(1'b1, 1, SAMPLE_MAX, 1'b0);
    push_reading(1'b1, SAMPLE_MAX, 1, 1'b1);
    push_reading(1'b1, 2, 2, 1'b0);
    wait_idle();

    for (int b = 0; b < BATCHES; b++) begin
      if (b == BATCHES / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 10;
      end else if (b == 2 * BATCHES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (b)
        1: load_calibration(1, -GAIN_LIMIT, GAIN_LIMIT, -OFFSET_SPAN / 2, OFFSET_SPAN / 2 - 1);
        2: load_calibration(0, rand_gain(), rand_gain(), rand_offset(), rand_offset());
        3: load_calibration(1, 0, 0, rand_offset(), rand_offset());
        4: load_calibration(1, -(1 << FRAC_BITS) - 1, -1, 0, 0);
        default: load_calibration(1, rand_gain(), rand_gain(), rand_offset(), rand_offset());
      endcase
      queue_random_readings(READINGS_PER_BATCH);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && coord_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
